// ----- hw/rtl/source_text_lexer_assert.svh -----
// Assertion macros shared by the source text lexer modules.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SOURCE_TEXT_LEXER_ASSERT_SVH
`define SOURCE_TEXT_LEXER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SLX_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define SLX_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

// ----- hw/rtl/slx_pkg.sv -----
// Shared types and constants of the source text lexer.
// Used by slx_front, slx_queue, slx_back and source_text_lexer; no dependencies.
package slx_pkg;

    localparam int unsigned MAX_PART_LENGTH = 1024;
    localparam int LEN_W   = 11;
    localparam int KIND_W  = 5;
    localparam int KW_W    = 2;
    localparam int INT_W   = 32;
    localparam int FRAC_W  = 30;
    localparam int SCALE_W = 4;

    localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(MAX_PART_LENGTH);
    localparam logic [SCALE_W-1:0] FRAC_KEEP = 4'd9;

    // Result slots per character: held symbol, part, single symbol or flushed hold
    localparam int NUM_SLOTS   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NAME    = 5'd1;
    localparam logic [KIND_W-1:0] KIND_INT     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT   = 5'd3;
    localparam logic [KIND_W-1:0] KIND_EQ      = 5'd4;
    localparam logic [KIND_W-1:0] KIND_NOT     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_NE      = 5'd6;
    localparam logic [KIND_W-1:0] KIND_GE      = 5'd7;
    localparam logic [KIND_W-1:0] KIND_GT      = 5'd8;
    localparam logic [KIND_W-1:0] KIND_LE      = 5'd9;
    localparam logic [KIND_W-1:0] KIND_LT      = 5'd10;
    localparam logic [KIND_W-1:0] KIND_AND     = 5'd11;
    localparam logic [KIND_W-1:0] KIND_OR      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_STAR    = 5'd16;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd17;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd18;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd19;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd20;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd21;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd22;
    localparam logic [KIND_W-1:0] KIND_INVALID = 5'd23;
    localparam logic [KIND_W-1:0] KIND_NONE    = 5'd0;

    // Keyword codes
    localparam logic [KW_W-1:0] KW_IF    = 2'd0;
    localparam logic [KW_W-1:0] KW_WHILE = 2'd1;
    localparam logic [KW_W-1:0] KW_FOR   = 2'd2;
    localparam logic [KW_W-1:0] KW_PRINT = 2'd3;

    // Codes of a symbol waiting to be joined with the next byte
    typedef enum logic [2:0] {
        HOLD_EQ  = 3'd0,
        HOLD_GT  = 3'd1,
        HOLD_LT  = 3'd2,
        HOLD_NOT = 3'd3,
        HOLD_AMP = 3'd4,
        HOLD_BAR = 3'd5
    } hold_code_t;

    // Classification state of the part being collected
    typedef struct packed {
        logic [LEN_W-1:0]   count;
        logic               name_p;
        logic               num_p;
        logic [1:0]         dots;
        logic [3:0]         cand;
        logic [INT_W-1:0]   iacc;
        logic [FRAC_W-1:0]  facc;
        logic [SCALE_W-1:0] fcnt;
    } part_state_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KW_W-1:0]    kw;
        logic [LEN_W-1:0]   len;
        logic [INT_W-1:0]   ival;
        logic [FRAC_W-1:0]  fval;
        logic [SCALE_W-1:0] scale;
    } token_t;

    // All results caused by one character
    typedef struct packed {
        logic                       eot;
        logic [NUM_SLOTS-1:0]       tok_valid;
        token_t [NUM_SLOTS-1:0]     tok;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- hw/rtl/source_text_lexer.sv -----
// Source text lexer top level: one character per cycle in, one token per cycle out,
// unless the queue is full or out_ready is low. A token is registered in the bundle queue,
// then in the output register of slx_back. Throughput: one character per cycle while each
// character yields at most one token; a character that yields two or three tokens sends them
// one after another, and a four-transaction bundle queue absorbs such bursts. Reset clears
// queue, part and hold. Depends on slx_pkg, slx_front, slx_queue and slx_back.

module source_text_lexer
    import slx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_code,
    input  logic                end_of_text,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   token_kind,
    output logic [KW_W-1:0]     keyword_index,
    output logic [LEN_W-1:0]    part_length,
    output logic [INT_W-1:0]    integer_digits_value,
    output logic [FRAC_W-1:0]   fraction_digits_value,
    output logic [SCALE_W-1:0]  fraction_scale,
    output logic                last_token
);

    queue_status_t q_status;
    logic          push;
    bundle_t       push_data;
    logic          pop;
    bundle_t       head;
    token_t        out_tok;

    slx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    slx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    slx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_tok   (out_tok),
        .out_last  (last_token)
    );

    // Split the token record onto its ports
    assign token_kind            = out_tok.kind;
    assign keyword_index         = out_tok.kw;
    assign part_length           = out_tok.len;
    assign integer_digits_value  = out_tok.ival;
    assign fraction_digits_value = out_tok.fval;
    assign fraction_scale        = out_tok.scale;

endmodule

// ----- hw/rtl/slx_front.sv -----
// Front end of the source text lexer: accepts characters, tracks part state
// and the held symbol, and builds one bundle of up to three tokens per character.
// Depends on slx_pkg and source_text_lexer_assert.svh.
`include "source_text_lexer_assert.svh"

module slx_front
    import slx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_code,
    input  logic          end_of_text,
    input  queue_status_t q_status,
    output logic          push,
    output bundle_t       push_data
);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    function automatic part_state_t part_cleared();
        part_state_t s;
        s        = '0;
        s.name_p = 1'b1;
        s.num_p  = 1'b1;
        s.cand   = 4'hF;
        return s;
    endfunction

    function automatic logic [LEN_W-1:0] kw_len(input logic [KW_W-1:0] k);
        logic [LEN_W-1:0] l;
        unique case (k)
            KW_IF:    l = LEN_W'(2);
            KW_WHILE: l = LEN_W'(5);
            KW_FOR:   l = LEN_W'(3);
            KW_PRINT: l = LEN_W'(5);
            default:  l = LEN_W'(5);
        endcase
        return l;
    endfunction

    function automatic logic [7:0] kw_char(input logic [KW_W-1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        unique case ({k, pos})
            {KW_IF, 3'd0}:    ch = 8'h69; // i
            {KW_IF, 3'd1}:    ch = 8'h66; // f
            {KW_WHILE, 3'd0}: ch = 8'h77; // w
            {KW_WHILE, 3'd1}: ch = 8'h68; // h
            {KW_WHILE, 3'd2}: ch = 8'h69; // i
            {KW_WHILE, 3'd3}: ch = 8'h6C; // l
            {KW_WHILE, 3'd4}: ch = 8'h65; // e
            {KW_FOR, 3'd0}:   ch = 8'h66; // f
            {KW_FOR, 3'd1}:   ch = 8'h6F; // o
            {KW_FOR, 3'd2}:   ch = 8'h72; // r
            {KW_PRINT, 3'd0}: ch = 8'h70; // p
            {KW_PRINT, 3'd1}: ch = 8'h72; // r
            {KW_PRINT, 3'd2}: ch = 8'h69; // i
            {KW_PRINT, 3'd3}: ch = 8'h6E; // n
            {KW_PRINT, 3'd4}: ch = 8'h74; // t
            default:          ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_hold(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_GT) || (c == CH_LT) ||
               (c == CH_BANG) || (c == CH_AMP) || (c == CH_BAR);
    endfunction

    function automatic logic [2:0] hold_of(input logic [7:0] c);
        logic [2:0] h;
        unique case (c)
            CH_EQ:   h = HOLD_EQ;
            CH_GT:   h = HOLD_GT;
            CH_LT:   h = HOLD_LT;
            CH_BANG: h = HOLD_NOT;
            CH_AMP:  h = HOLD_AMP;
            CH_BAR:  h = HOLD_BAR;
            default: h = HOLD_EQ;
        endcase
        return h;
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_SLASH:  k = KIND_SLASH;
            CH_STAR:   k = KIND_STAR;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic pair_match(input logic [2:0] h, input logic [7:0] c);
        logic m;
        unique case (h)
            HOLD_EQ, HOLD_GT, HOLD_LT, HOLD_NOT: m = (c == CH_EQ);
            HOLD_AMP: m = (c == CH_AMP);
            HOLD_BAR: m = (c == CH_BAR);
            default:  m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [2:0] h);
        logic [KIND_W-1:0] k;
        unique case (h)
            HOLD_EQ:  k = KIND_EQ;
            HOLD_GT:  k = KIND_GE;
            HOLD_LT:  k = KIND_LE;
            HOLD_NOT: k = KIND_NE;
            HOLD_AMP: k = KIND_AND;
            HOLD_BAR: k = KIND_OR;
            default:  k = KIND_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] lone_kind(input logic [2:0] h);
        logic [KIND_W-1:0] k;
        unique case (h)
            HOLD_GT:  k = KIND_GT;
            HOLD_LT:  k = KIND_LT;
            HOLD_NOT: k = KIND_NOT;
            default:  k = KIND_INVALID;
        endcase
        return k;
    endfunction

    function automatic token_t symbol_token(input logic [KIND_W-1:0] kind,
                                            input logic [LEN_W-1:0] len);
        token_t t;
        t      = '0;
        t.kind = kind;
        t.len  = len;
        return t;
    endfunction

    // Fold one character into the part state
    function automatic part_state_t add_char(input part_state_t s, input logic [7:0] c);
        part_state_t n;
        logic        lower;
        logic        digit;
        logic        under;
        logic [3:0]  d;
        n     = s;
        lower = (c >= 8'h61) && (c <= 8'h7A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        under = (c == CH_UNDER);
        d     = c[3:0];
        if (s.count == '0)
        begin
            n.name_p = lower || under;
        end
        else
        begin
            n.name_p = s.name_p && (lower || digit || under);
        end
        if (c == CH_DOT)
        begin
            if (s.dots < 2'd2)
            begin
                n.dots = s.dots + 2'd1;
            end
            if (n.dots >= 2'd2)
            begin
                n.num_p = 1'b0;
            end
        end
        else if (digit)
        begin
            if (s.dots == 2'd0)
            begin
                n.iacc = INT_W'(s.iacc * 32'd10) + {28'd0, d};
            end
            else if (s.fcnt < FRAC_KEEP)
            begin
                n.facc = FRAC_W'(s.facc * 30'd10) + {26'd0, d};
                n.fcnt = s.fcnt + 4'd1;
            end
        end
        else
        begin
            n.num_p = 1'b0;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (s.cand[k] && !((s.count < kw_len(KW_W'(k))) &&
                               (c == kw_char(KW_W'(k), s.count[2:0]))))
            begin
                n.cand[k] = 1'b0;
            end
        end
        if (s.count < MAX_LEN)
        begin
            n.count = s.count + 1'b1;
        end
        return n;
    endfunction

    // Turn a finished part into its token
    function automatic token_t classify_part(input part_state_t s);
        token_t t;
        logic   hit;
        t     = '0;
        t.len = s.count;
        hit   = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!hit && s.cand[k] && (s.count == kw_len(KW_W'(k))))
            begin
                hit    = 1'b1;
                t.kind = KIND_KEYWORD;
                t.kw   = KW_W'(k);
            end
        end
        if (!hit)
        begin
            priority if (s.name_p)
            begin
                t.kind = KIND_NAME;
            end
            else if (s.num_p && (s.dots == 2'd0))
            begin
                t.kind = KIND_INT;
                t.ival = s.iacc;
            end
            else if (s.num_p && (s.dots == 2'd1))
            begin
                t.kind  = KIND_FLOAT;
                t.ival  = s.iacc;
                t.fval  = s.facc;
                t.scale = s.fcnt;
            end
            else
            begin
                t.kind = KIND_INVALID;
            end
        end
        return t;
    endfunction

    part_state_t part_reg, part_next;
    logic [2:0]  held_sym_reg, held_sym_next;
    logic        held_valid_reg, held_valid_next;

    logic              accept;
    logic              consumed;
    logic              hold_hit;
    logic [KIND_W-1:0] sk;
    logic              stop;
    part_state_t       added;
    part_state_t       mid_part;
    part_state_t       emit_src;
    logic              held_mid_valid;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Classify the character and build the token bundle
    always_comb
    begin
        consumed       = held_valid_reg && pair_match(held_sym_reg, char_code);
        hold_hit       = is_hold(char_code);
        sk             = single_kind(char_code);
        stop           = !consumed && (hold_hit || (sk != KIND_NONE) || (char_code == CH_SPACE));
        added          = add_char(part_reg, char_code);
        held_mid_valid = stop && hold_hit;

        if (consumed)
        begin
            mid_part = part_reg;
        end
        else if (stop)
        begin
            mid_part = part_cleared();
        end
        else
        begin
            mid_part = added;
        end
        emit_src = stop ? part_reg : mid_part;

        push_data     = '0;
        push_data.eot = end_of_text;

        // Slot 0: the symbol held from the previous character
        push_data.tok_valid[0] = held_valid_reg;
        push_data.tok[0] = consumed ? symbol_token(pair_kind(held_sym_reg), LEN_W'(2))
                                    : symbol_token(lone_kind(held_sym_reg), LEN_W'(1));

        // Slot 1: the part ended by a stop character or by end of text
        push_data.tok_valid[1] = stop ? (part_reg.count != '0)
                                      : (end_of_text && (mid_part.count != '0));
        push_data.tok[1] = classify_part(emit_src);

        // Slot 2: a single symbol, or a new hold flushed at end of text
        if (stop && (sk != KIND_NONE))
        begin
            push_data.tok_valid[2] = 1'b1;
            push_data.tok[2]       = symbol_token(sk, LEN_W'(1));
        end
        else
        begin
            push_data.tok_valid[2] = end_of_text && held_mid_valid;
            push_data.tok[2]       = symbol_token(lone_kind(hold_of(char_code)), LEN_W'(1));
        end

        push = accept && (push_data.tok_valid != '0);

        // Advance state; end of text starts a fresh text
        if (end_of_text)
        begin
            part_next       = part_cleared();
            held_valid_next = 1'b0;
            held_sym_next   = HOLD_EQ;
        end
        else
        begin
            part_next       = mid_part;
            held_valid_next = held_mid_valid;
            held_sym_next   = held_mid_valid ? hold_of(char_code) : held_sym_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg       <= part_cleared();
            held_sym_reg   <= HOLD_EQ;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            part_reg       <= part_next;
            held_sym_reg   <= held_sym_next;
            held_valid_reg <= held_valid_next;
        end
    end

    `SLX_ASSERT_NEXT(a_eot_flush, accept && end_of_text, !held_valid_reg && (part_reg.count == '0), "state not flushed after end of text")

endmodule

// ----- hw/rtl/slx_queue.sv -----
// Bundle queue between the lexer front end and the token output stage.
// Depends on slx_pkg and source_text_lexer_assert.svh.
`include "source_text_lexer_assert.svh"

module slx_queue
    import slx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bundle_t       push_data,
    input  logic          pop,
    output bundle_t       head,
    output queue_status_t status
);

    bundle_t mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming bundle
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `SLX_ASSERT_NOW(a_no_overflow, !(push && status.full), "push into full queue")
    `SLX_ASSERT_NOW(a_no_underflow, !(pop && status.empty), "pop from empty queue")
    `SLX_ASSERT_NOW(a_count_range, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ----- hw/rtl/slx_back.sv -----
// Token output stage of the source text lexer: walks the head bundle slot by
// slot into a registered output. Depends on slx_pkg and source_text_lexer_assert.svh.
`include "source_text_lexer_assert.svh"

module slx_back
    import slx_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bundle_t       head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output token_t        out_tok,
    output logic          out_last
);

    logic [NUM_SLOTS-1:0] done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;
    token_t               out_tok_reg, out_tok_next;
    logic                 out_last_reg, out_last_next;

    logic [NUM_SLOTS-1:0] pend;
    logic [NUM_SLOTS-1:0] sel_mask;
    logic                 last_slot;
    logic                 load;

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;
    assign out_last  = out_last_reg;

    // Pick the first slot not yet sent and load it when the output frees up
    always_comb
    begin
        pend = head.tok_valid & ~done_reg;
        priority if (pend[0])
        begin
            sel_mask     = 3'b001;
            out_tok_next = head.tok[0];
        end
        else if (pend[1])
        begin
            sel_mask     = 3'b010;
            out_tok_next = head.tok[1];
        end
        else
        begin
            sel_mask     = 3'b100;
            out_tok_next = head.tok[2];
        end
        last_slot     = ((pend & ~sel_mask) == '0);
        load          = !q_status.empty && (!out_valid_reg || out_ready);
        pop           = load && last_slot;
        out_last_next = head.eot && last_slot;

        if (load)
        begin
            out_valid_next = 1'b1;
            done_next      = last_slot ? '0 : (done_reg | sel_mask);
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            done_next      = done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload until the next load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_tok_reg  <= out_tok_next;
            out_last_reg <= out_last_next;
        end
    end

    `SLX_ASSERT_NOW(a_no_empty_bundle, q_status.empty || (head.tok_valid != '0), "empty bundle in queue")
    `SLX_ASSERT_NEXT(a_pop_clears_done, pop, done_reg == '0, "slot marks kept after pop")

endmodule

// ----- tb/source_text_lexer_test.sv -----
// Self-checking testbench for source_text_lexer: a token predictor in a scoreboard class,
// plus character and token handshake drivers with random stalls and a long output hold-off.
// Depends on slx_pkg and the source_text_lexer RTL.

module source_text_lexer_test;
    import slx_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 290;
    localparam int LONG_DIGITS  = 14;

    typedef struct packed {
        token_t tok;
        logic   last;
    } lexeme_t;

    class lexeme_scoreboard;
        lexeme_t          expected_tokens[$];
        int unsigned      mismatches;
        // Part being collected
        logic [LEN_W-1:0]   part_len;
        logic               name_ok;
        logic               number_ok;
        logic [1:0]         dots_seen;
        logic [3:0]         kw_cand;
        logic [INT_W-1:0]   int_acc;
        logic [FRAC_W-1:0]  frac_acc;
        logic [SCALE_W-1:0] frac_cnt;
        // Symbol waiting for a possible second byte
        hold_code_t         held_code;
        logic               held_v;

        function new();
            mismatches = 0;
            clear_part();
            held_code = HOLD_EQ;
            held_v    = 1'b0;
        endfunction

        function string keyword_text(int k);
            case (k)
                KW_IF:    return "if";
                KW_WHILE: return "while";
                KW_FOR:   return "for";
                default:  return "print";
            endcase
        endfunction

        function void clear_part();
            part_len  = '0;
            name_ok   = 1'b1;
            number_ok = 1'b1;
            dots_seen = '0;
            kw_cand   = 4'hF;
            int_acc   = '0;
            frac_acc  = '0;
            frac_cnt  = '0;
        endfunction

        function void push_token(logic [KIND_W-1:0] kind, logic [KW_W-1:0] kw,
                                 logic [LEN_W-1:0] len, logic [INT_W-1:0] iv,
                                 logic [FRAC_W-1:0] fv, logic [SCALE_W-1:0] sc);
            lexeme_t t;
            t.tok.kind  = kind;
            t.tok.kw    = kw;
            t.tok.len   = len;
            t.tok.ival  = iv;
            t.tok.fval  = fv;
            t.tok.scale = sc;
            t.last      = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        // Classify the finished part and start a new one
        function void flush_part();
            bit kw_hit;
            string kw;
            kw_hit = 1'b0;
            for (int k = 0; k < 4; k++) begin
                kw = keyword_text(k);
                if (!kw_hit && kw_cand[k] && part_len == kw.len()) begin
                    push_token(KIND_KEYWORD, KW_W'(k), part_len, '0, '0, '0);
                    kw_hit = 1'b1;
                end
            end
            if (!kw_hit) begin
                if (name_ok)
                    push_token(KIND_NAME, '0, part_len, '0, '0, '0);
                else if (number_ok && dots_seen == 2'd0)
                    push_token(KIND_INT, '0, part_len, int_acc, '0, '0);
                else if (number_ok && dots_seen == 2'd1)
                    push_token(KIND_FLOAT, '0, part_len, int_acc, frac_acc, frac_cnt);
                else
                    push_token(KIND_INVALID, '0, part_len, '0, '0, '0);
            end
            clear_part();
        endfunction

        function void flush_held();
            logic [KIND_W-1:0] kind;
            case (held_code)
                HOLD_GT:  kind = KIND_GT;
                HOLD_LT:  kind = KIND_LT;
                HOLD_NOT: kind = KIND_NOT;
                default:  kind = KIND_INVALID;
            endcase
            held_v = 1'b0;
            push_token(kind, '0, LEN_W'(1), '0, '0, '0);
        endfunction

        // Update the classification flags and accumulators with one part byte
        function void add_char(logic [7:0] c);
            bit lower;
            bit digit;
            logic [3:0] d;
            string kw;
            lower = (c >= "a" && c <= "z");
            digit = (c >= "0" && c <= "9");
            d     = 4'(c - "0");
            if (part_len == '0)
                name_ok = lower || c == "_";
            else
                name_ok = name_ok && (lower || digit || c == "_");
            if (c == ".") begin
                if (dots_seen < 2'd2)
                    dots_seen++;
                if (dots_seen >= 2'd2)
                    number_ok = 1'b0;
            end else if (digit) begin
                if (dots_seen == 2'd0) begin
                    int_acc = int_acc * 32'd10 + INT_W'(d);
                end else if (frac_cnt < FRAC_KEEP) begin
                    frac_acc = FRAC_W'(frac_acc * 32'd10 + 32'(d));
                    frac_cnt++;
                end
            end else begin
                number_ok = 1'b0;
            end
            for (int k = 0; k < 4; k++) begin
                kw = keyword_text(k);
                if (kw_cand[k] && !(part_len < kw.len() && c == kw[part_len]))
                    kw_cand[k] = 1'b0;
            end
            if (part_len < MAX_LEN)
                part_len++;
        endfunction

        // Predict the tokens caused by one accepted character transaction
        function void note_input(logic [7:0] c, logic eot);
            int start_size;
            bit consumed;
            bit is_hold;
            hold_code_t h;
            logic [7:0] second;
            logic [KIND_W-1:0] pair_kind;
            logic [KIND_W-1:0] single;
            lexeme_t t;
            start_size = expected_tokens.size();
            consumed   = 1'b0;
            // Join the held symbol with this byte, or emit it alone
            if (held_v) begin
                case (held_code)
                    HOLD_AMP: begin second = "&"; pair_kind = KIND_AND; end
                    HOLD_BAR: begin second = "|"; pair_kind = KIND_OR;  end
                    HOLD_GT:  begin second = "="; pair_kind = KIND_GE;  end
                    HOLD_LT:  begin second = "="; pair_kind = KIND_LE;  end
                    HOLD_NOT: begin second = "="; pair_kind = KIND_NE;  end
                    default:  begin second = "="; pair_kind = KIND_EQ;  end
                endcase
                if (c == second) begin
                    push_token(pair_kind, '0, LEN_W'(2), '0, '0, '0);
                    held_v   = 1'b0;
                    consumed = 1'b1;
                end else begin
                    flush_held();
                end
            end
            if (!consumed) begin
                is_hold = 1'b1;
                h       = HOLD_EQ;
                case (c)
                    "=":     h = HOLD_EQ;
                    ">":     h = HOLD_GT;
                    "<":     h = HOLD_LT;
                    "!":     h = HOLD_NOT;
                    "&":     h = HOLD_AMP;
                    "|":     h = HOLD_BAR;
                    default: is_hold = 1'b0;
                endcase
                case (c)
                    "+":     single = KIND_PLUS;
                    "-":     single = KIND_MINUS;
                    "/":     single = KIND_SLASH;
                    "*":     single = KIND_STAR;
                    "(":     single = KIND_LPAREN;
                    ")":     single = KIND_RPAREN;
                    "{":     single = KIND_LBRACE;
                    "}":     single = KIND_RBRACE;
                    ",":     single = KIND_COMMA;
                    ";":     single = KIND_SEMI;
                    default: single = KIND_NONE;
                endcase
                if (is_hold || single != KIND_NONE || c == " ") begin
                    if (part_len != '0)
                        flush_part();
                    if (is_hold) begin
                        held_code = h;
                        held_v    = 1'b1;
                    end else if (single != KIND_NONE) begin
                        push_token(single, '0, LEN_W'(1), '0, '0, '0);
                    end
                end else begin
                    add_char(c);
                end
            end
            // Flush everything at end of text and mark the final token
            if (eot) begin
                if (part_len != '0)
                    flush_part();
                if (held_v)
                    flush_held();
                clear_part();
                held_code = HOLD_EQ;
                held_v    = 1'b0;
                if (expected_tokens.size() > start_size) begin
                    t = expected_tokens.pop_back();
                    t.last = 1'b1;
                    expected_tokens.push_back(t);
                end
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
            mismatches++;
        endtask

        // Compare one accepted token transaction with the oldest prediction
        task check_result(logic [KIND_W-1:0] kind, logic [KW_W-1:0] kw, logic [LEN_W-1:0] len,
                          logic [INT_W-1:0] iv, logic [FRAC_W-1:0] fv,
                          logic [SCALE_W-1:0] sc, logic last);
            lexeme_t want;
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected token, kind", 32'd0, 32'(kind));
            end else begin
                want = expected_tokens.pop_front();
                if (kind !== want.tok.kind)
                    report_mismatch("token_kind", 32'(want.tok.kind), 32'(kind));
                if (kw !== want.tok.kw)
                    report_mismatch("keyword_index", 32'(want.tok.kw), 32'(kw));
                if (len !== want.tok.len)
                    report_mismatch("part_length", 32'(want.tok.len), 32'(len));
                if (iv !== want.tok.ival)
                    report_mismatch("integer_digits_value", want.tok.ival, iv);
                if (fv !== want.tok.fval)
                    report_mismatch("fraction_digits_value", 32'(want.tok.fval), 32'(fv));
                if (sc !== want.tok.scale)
                    report_mismatch("fraction_scale", 32'(want.tok.scale), 32'(sc));
                if (last !== want.last)
                    report_mismatch("last_token", 32'(want.last), 32'(last));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         char_code;
    logic               end_of_text;
    logic               out_valid;
    logic               out_ready;
    logic [KIND_W-1:0]  token_kind;
    logic [KW_W-1:0]    keyword_index;
    logic [LEN_W-1:0]   part_length;
    logic [INT_W-1:0]   integer_digits_value;
    logic [FRAC_W-1:0]  fraction_digits_value;
    logic [SCALE_W-1:0] fraction_scale;
    logic               last_token;

    lexeme_scoreboard sb = new();

    bit           quiet;
    bit           hold_request;
    int unsigned  random_sent;
    int unsigned  cycle_count;
    byte unsigned lexeme_buf[$];

    string symbol_texts[22] = '{"==", "!=", ">=", "<=", "&&", "||", "=", "&", "|", "!", ">",
                                "<", "+", "-", "/", "*", "(", ")", "{", "}", ",", ";"};

    source_text_lexer i_dut (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one character transaction, with random idle cycles in front of it
    task automatic send_char(input logic [7:0] c, input logic eot);
        while (!quiet && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_code   <= c;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s, input bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eot_at_end && i == s.len() - 1);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            lexeme_buf.push_back(s[i]);
    endfunction

    // Build one mostly well-formed lexeme with random content and send it
    task automatic send_random_lexeme();
        int pick;
        int r;
        pick = $urandom_range(99);
        lexeme_buf.delete();
        if (pick < 15) begin
            push_text(sb.keyword_text($urandom_range(3)));
            r = $urandom_range(7);
            if (r == 0)
                lexeme_buf.push_back(8'("a" + $urandom_range(25)));
            else if (r == 1)
                void'(lexeme_buf.pop_back());
        end else if (pick < 33) begin
            lexeme_buf.push_back($urandom_range(3) == 0 ? 8'("_") : 8'("a" + $urandom_range(25)));
            repeat ($urandom_range(6)) begin
                r = $urandom_range(36);
                lexeme_buf.push_back(r < 26 ? 8'("a" + r) : (r < 36 ? 8'("0" + r - 26) : 8'("_")));
            end
        end else if (pick < 48) begin
            repeat ($urandom_range(1, 12))
                lexeme_buf.push_back(8'("0" + $urandom_range(9)));
        end else if (pick < 60) begin
            repeat ($urandom_range(3))
                lexeme_buf.push_back(8'("0" + $urandom_range(9)));
            lexeme_buf.push_back(".");
            repeat ($urandom_range(11))
                lexeme_buf.push_back(8'("0" + $urandom_range(9)));
        end else if (pick < 80) begin
            push_text(symbol_texts[$urandom_range(21)]);
        end else if (pick < 90) begin
            case ($urandom_range(3))
                0: push_text("Ab");
                1: push_text("1.2.3");
                2: push_text("9x");
                default: push_text("a..");
            endcase
        end else begin
            repeat ($urandom_range(1, 3))
                lexeme_buf.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(1) == 0)
            lexeme_buf.push_back(" ");
        foreach (lexeme_buf[i]) begin
            send_char(lexeme_buf[i], $urandom_range(39) == 0);
            random_sent++;
        end
    endtask

    // Stimulus
    initial begin
        int hold_count;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        char_code   = '0;
        end_of_text = 1'b0;
        quiet       = 1'b0;
        hold_request = 1'b0;
        random_sent = 0;
        hold_count  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keyword, joined symbol, two dots
        send_text("print!=1..2", 1'b0);
        // Lone dot, lone = before an upper-case part, lone & flushed at end of text
        send_text(" .=A&", 1'b1);
        // Extreme bytes, flushed as one invalid part
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        // Integer wrap and dropped fraction digits, then a lone |
        send_text("4294967299.1234567890|", 1'b0);
        // Long float part: the integer digits wrap
        for (int i = 0; i < LONG_DIGITS; i++)
            send_char("7", 1'b0);
        send_text(".5;", 1'b1);

        // Random lexeme stream with a quiet stretch and output hold-offs
        while (random_sent < RANDOM_ITEMS) begin
            quiet = random_sent >= 120 && random_sent < 200;
            if ((hold_count == 0 && random_sent >= 60) || (hold_count == 1 && random_sent >= 250)) begin
                hold_request = 1'b1;
                hold_count++;
            end
            send_random_lexeme();
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Drain outstanding tokens, then watch for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Token receiver: random stalls, plus a long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
            end
            out_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // Monitor both channels at each edge
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (in_valid && in_ready)
                    sb.note_input(char_code, end_of_text);
                if (out_valid && out_ready)
                    sb.check_result(token_kind, keyword_index, part_length, integer_digits_value,
                                    fraction_digits_value, fraction_scale, last_token);
            end
        end
    end

    // Watchdog
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
